// File: src/lz77gd_pkg.sv
// Shared types, constants and helpers for the LZ77 gamma decompressor.
package lz77gd_pkg;

  localparam int unsigned WinDepth = 65536;
  localparam int unsigned WinAw    = $clog2(WinDepth);
  localparam int unsigned PosW     = 17;
  localparam int unsigned MaxBlock = 65536;
  localparam int unsigned MaxUnary = 16;

  typedef enum logic [2:0] {
    PhFlag   = 3'd0,
    PhLit    = 3'd1,
    PhUnary  = 3'd2,
    PhRem    = 3'd3,
    PhOff    = 3'd4,
    PhLitOut = 3'd5,
    PhCopy   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    StByteOut  = 3'd0,
    StPushOk   = 3'd1,
    StPushRef  = 3'd2,
    StNeedIn   = 3'd3,
    StError    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CmdPush = 1'b0,
    CmdPull = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    SIdle,
    SParse,
    SRead,
    SWrite,
    SResp
  } ctl_e;

  // Bits needed to code an offset below n (ceil of log2 n).
  function automatic logic [4:0] ceil_log2(input logic [PosW-1:0] n);
    logic [PosW-1:0] m;
    logic [4:0]      b;
    m = n - PosW'(1);
    b = '0;
    if (n > PosW'(1)) begin
      for (int i = 0; i < PosW; i++) begin
        if (m[i]) b = 5'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

// File: src/lz77_gamma_decompressor.sv
// LZ77 gamma decompressor top level: bit parser, window memory, sequencer.
//
//  channel | direction | handshake              | word
//  in      | sink      | in_valid_i/in_ready_o  | command_i, data_byte_i
//  out     | source    | out_valid_o/out_ready_i| status_o, out_byte_o, block_last_o
//  cfg     | sink      | cfg_we_i               | cfg_data_i (block_length)
//
// Sequence: a push loads the byte and parses its bits (up to 8), one bit per cycle
// through the shared bit parser, then closes; a literal pull writes the window and a
// copy pull reads then writes it, both then parsing buffered bits; a pull that ends the
// block skips parsing. Refused, need-input and error words go straight to the result
// word. Every path ends with the result word.
// Reset clears all control state; the window memory is not cleared, since
// a copy only reads bytes already written in the current block.
// A stalled result word holds the block; no input word is taken until the
// result is taken.
module lz77_gamma_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        block_last_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i
);
  import lz77gd_pkg::*;

  ctl_e            ctl_q, ctl_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      buf_q, buf_d;
  logic [3:0]      bits_q, bits_d;
  logic [4:0]      uc_q, uc_d;
  logic [PosW-1:0] acc_q, acc_d;
  logic [4:0]      fbl_q, fbl_d;
  logic [WinAw-1:0] off_q, off_d;
  logic [PosW-1:0] copy_q, copy_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            err_q, err_d;
  logic [PosW-1:0] blen_q;
  logic            pull_q, pull_d;
  status_e         status_q, status_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;

  logic [7:0]      win_mem [WinDepth];
  logic [7:0]      rd_q;
  logic [WinAw-1:0] src_addr;
  logic [7:0]      wr_byte;
  logic            parse_done;
  logic            in_acc;

  assign in_acc     = in_valid_i && in_ready_o;
  assign parse_done = (bits_q == 4'd0) || (phase_q == PhLitOut) ||
                      (phase_q == PhCopy) || err_q;
  assign src_addr   = WinAw'(pos_q - PosW'(off_q) - PosW'(1));
  assign wr_byte    = (phase_q == PhLitOut) ? acc_q[7:0] : rd_q;

  // Block length register; out-of-range values act as a full block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= PosW'(MaxBlock);
    end else if (cfg_we_i) begin
      if (cfg_data_i == '0 || cfg_data_i > PosW'(MaxBlock)) blen_q <= PosW'(MaxBlock);
      else blen_q <= cfg_data_i;
    end
  end

  // Window memory: read the copy source, then write the output byte.
  always_ff @(posedge clk_i) begin
    if (ctl_q == SRead) rd_q <= win_mem[src_addr];
    if (ctl_q == SWrite) win_mem[pos_q[WinAw-1:0]] <= wr_byte;
  end

  // Sequencer next state.
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      SIdle: begin
        if (in_acc) begin
          if (err_q) ctl_d = SResp;
          else if (command_i == CmdPush) ctl_d = (bits_q != 4'd0) ? SResp : SParse;
          else if (phase_q == PhLitOut) ctl_d = SWrite;
          else if (phase_q == PhCopy) ctl_d = SRead;
          else ctl_d = SResp;
        end
      end
      SParse: if (parse_done) ctl_d = SResp;
      SRead:  ctl_d = SWrite;
      SWrite: ctl_d = (pos_q + PosW'(1) >= blen_q) ? SResp : SParse;
      SResp:  if (out_ready_i) ctl_d = SIdle;
      default: ctl_d = SIdle;
    endcase
  end

  // Sequencer outputs and datapath.
  always_comb begin
    logic            bit_v;
    logic [PosW-1:0] win;
    logic [4:0]      obits;
    logic [PosW:0]   len;
    logic            do_start;
    logic            do_finish;
    logic [PosW-1:0] fin_acc;

    phase_d  = phase_q;
    buf_d    = buf_q;
    bits_d   = bits_q;
    uc_d     = uc_q;
    acc_d    = acc_q;
    fbl_d    = fbl_q;
    off_d    = off_q;
    copy_d   = copy_q;
    pos_d    = pos_q;
    err_d    = err_q;
    pull_d   = pull_q;
    status_d = status_q;
    byte_d   = byte_q;
    last_d   = last_q;

    bit_v     = buf_q[7];
    win       = (pos_q < PosW'(WinDepth)) ? pos_q : PosW'(WinDepth);
    obits     = ceil_log2(win);
    len       = '0;
    do_start  = 1'b0;
    do_finish = 1'b0;
    fin_acc   = acc_q;

    unique case (ctl_q)
      SIdle: begin
        if (in_acc) begin
          pull_d = command_i;
          byte_d = '0;
          last_d = 1'b0;
          if (err_q) begin
            status_d = StError;
          end else if (command_i == CmdPush) begin
            if (bits_q != 4'd0) begin
              status_d = StPushRef;
            end else begin
              buf_d  = data_byte_i;
              bits_d = 4'd8;
            end
          end else if (phase_q != PhLitOut && phase_q != PhCopy) begin
            status_d = StNeedIn;
          end
        end
      end
      SParse: begin
        if (parse_done) begin
          // Pulls answer with the byte even if parsing raised an error.
          if (pull_q) status_d = StByteOut;
          else status_d = err_q ? StError : StPushOk;
        end else begin
          buf_d  = {buf_q[6:0], 1'b0};
          bits_d = bits_q - 4'd1;
          case (phase_q)
            PhFlag: begin
              if (!bit_v) begin
                phase_d = PhLit;
                acc_d   = '0;
                fbl_d   = 5'd8;
              end else if (pos_q == '0) begin
                err_d = 1'b1;
              end else begin
                phase_d = PhUnary;
                uc_d    = '0;
              end
            end
            PhLit: begin
              acc_d = {9'd0, acc_q[6:0], bit_v};
              fbl_d = fbl_q - 5'd1;
              if (fbl_q == 5'd1) phase_d = PhLitOut;
            end
            PhUnary: begin
              if (bit_v) begin
                uc_d = uc_q + 5'd1;
                if (uc_q + 5'd1 > 5'(MaxUnary)) err_d = 1'b1;
              end else if (uc_q == '0) begin
                copy_d   = PosW'(2);
                do_start = 1'b1;
              end else begin
                phase_d = PhRem;
                acc_d   = '0;
                fbl_d   = uc_q;
              end
            end
            PhRem: begin
              acc_d = {acc_q[PosW-2:0], bit_v};
              fbl_d = fbl_q - 5'd1;
              if (fbl_q == 5'd1) begin
                len = (PosW+1)'(1) << uc_q;
                len = len + {1'b0, acc_q[PosW-2:0], bit_v} + (PosW+1)'(1);
                copy_d   = len[PosW] ? '1 : len[PosW-1:0];
                do_start = 1'b1;
              end
            end
            default: begin
              acc_d = {acc_q[PosW-2:0], bit_v};
              fbl_d = fbl_q - 5'd1;
              if (fbl_q == 5'd1) begin
                do_finish = 1'b1;
                fin_acc   = {acc_q[PosW-2:0], bit_v};
              end
            end
          endcase
          // Start the offset field; a window of one needs no offset bits.
          if (do_start) begin
            acc_d = '0;
            if (obits == '0) begin
              do_finish = 1'b1;
              fin_acc   = '0;
            end else begin
              fbl_d   = obits;
              phase_d = PhOff;
            end
          end
          if (do_finish) begin
            if (fin_acc >= win) begin
              err_d = 1'b1;
            end else begin
              off_d   = WinAw'(win - fin_acc - PosW'(1));
              phase_d = PhCopy;
            end
          end
        end
      end
      SRead: begin
      end
      SWrite: begin
        byte_d   = wr_byte;
        status_d = StByteOut;
        pos_d    = pos_q + PosW'(1);
        if (phase_q == PhLitOut) begin
          phase_d = PhFlag;
        end else begin
          copy_d = copy_q - PosW'(1);
          if (copy_q == PosW'(1)) phase_d = PhFlag;
        end
        // End of block: restart and drop padding bits.
        if (pos_q + PosW'(1) >= blen_q) begin
          last_d  = 1'b1;
          pos_d   = '0;
          copy_d  = '0;
          phase_d = PhFlag;
          bits_d  = '0;
          buf_d   = '0;
        end
      end
      SResp: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= SIdle;
      phase_q  <= PhFlag;
      buf_q    <= '0;
      bits_q   <= '0;
      uc_q     <= '0;
      acc_q    <= '0;
      fbl_q    <= '0;
      off_q    <= '0;
      copy_q   <= '0;
      pos_q    <= '0;
      err_q    <= 1'b0;
      pull_q   <= 1'b0;
      status_q <= StByteOut;
      last_q   <= 1'b0;
    end else begin
      ctl_q    <= ctl_d;
      phase_q  <= phase_d;
      buf_q    <= buf_d;
      bits_q   <= bits_d;
      uc_q     <= uc_d;
      acc_q    <= acc_d;
      fbl_q    <= fbl_d;
      off_q    <= off_d;
      copy_q   <= copy_d;
      pos_q    <= pos_d;
      err_q    <= err_d;
      pull_q   <= pull_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign in_ready_o   = (ctl_q == SIdle);
  assign out_valid_o  = (ctl_q == SResp);
  assign status_o     = status_q;
  assign out_byte_o   = byte_q;
  assign block_last_o = last_q;

  // The error flag never clears outside reset.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("error flag cleared");

  // The bit buffer never holds more than one byte.
  a_bits_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 4'd8) else $error("bit count overflow");

  // A last-byte word always carries a byte-out status.
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_q) |-> (status_q == StByteOut))
    else $error("block end without byte");

  // A window read only happens during a copy.
  a_read_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == SRead) |-> (phase_q == PhCopy)) else $error("read outside copy");

endmodule
